FILE: hdl/ima_enc_pkg.sv
// Shared types, constants and tables for the IMA ADPCM encoder.
`timescale 1ns / 1ps

package ima_enc_pkg;

  localparam logic [6:0]         INDEX_MAX = 7'd88;
  localparam logic signed [17:0] PRED_MAX  = 18'sd32767;
  localparam logic signed [17:0] PRED_MIN  = -18'sd32768;

  // Control for one accepted transaction moving out of the input register.
  typedef struct packed {
    logic advance;
    logic restart;
  } stage_ctl_t;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    unique case (idx)
      7'd0: s = 15'd7;       7'd1: s = 15'd8;       7'd2: s = 15'd9;
      7'd3: s = 15'd10;      7'd4: s = 15'd11;      7'd5: s = 15'd12;
      7'd6: s = 15'd13;      7'd7: s = 15'd14;      7'd8: s = 15'd16;
      7'd9: s = 15'd17;      7'd10: s = 15'd19;     7'd11: s = 15'd21;
      7'd12: s = 15'd23;     7'd13: s = 15'd25;     7'd14: s = 15'd28;
      7'd15: s = 15'd31;     7'd16: s = 15'd34;     7'd17: s = 15'd37;
      7'd18: s = 15'd41;     7'd19: s = 15'd45;     7'd20: s = 15'd50;
      7'd21: s = 15'd55;     7'd22: s = 15'd60;     7'd23: s = 15'd66;
      7'd24: s = 15'd73;     7'd25: s = 15'd80;     7'd26: s = 15'd88;
      7'd27: s = 15'd97;     7'd28: s = 15'd107;    7'd29: s = 15'd118;
      7'd30: s = 15'd130;    7'd31: s = 15'd143;    7'd32: s = 15'd157;
      7'd33: s = 15'd173;    7'd34: s = 15'd190;    7'd35: s = 15'd209;
      7'd36: s = 15'd230;    7'd37: s = 15'd253;    7'd38: s = 15'd279;
      7'd39: s = 15'd307;    7'd40: s = 15'd337;    7'd41: s = 15'd371;
      7'd42: s = 15'd408;    7'd43: s = 15'd449;    7'd44: s = 15'd494;
      7'd45: s = 15'd544;    7'd46: s = 15'd598;    7'd47: s = 15'd658;
      7'd48: s = 15'd724;    7'd49: s = 15'd796;    7'd50: s = 15'd876;
      7'd51: s = 15'd963;    7'd52: s = 15'd1060;   7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;   7'd55: s = 15'd1411;   7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;   7'd58: s = 15'd1878;   7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;   7'd61: s = 15'd2499;   7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;   7'd64: s = 15'd3327;   7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;   7'd67: s = 15'd4428;   7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;   7'd70: s = 15'd5894;   7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;   7'd73: s = 15'd7845;   7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;   7'd76: s = 15'd10442;  7'd77: s = 15'd11487;
      7'd78: s = 15'd12635;  7'd79: s = 15'd13899;  7'd80: s = 15'd15289;
      7'd81: s = 15'd16818;  7'd82: s = 15'd18500;  7'd83: s = 15'd20350;
      7'd84: s = 15'd22385;  7'd85: s = 15'd24623;  7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  // Index change from the magnitude bits of a code.
  function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
    logic signed [7:0] a;
    unique case (mag)
      3'd4: a = 8'sd2;
      3'd5: a = 8'sd4;
      3'd6: a = 8'sd6;
      3'd7: a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/ima_enc_quant.sv
// Predictor and step index state plus the 4-bit quantizer.
`timescale 1ns / 1ps

module ima_enc_quant (
  input  logic                     clk,
  input  logic                     rst,
  input  ima_enc_pkg::stage_ctl_t  ctl,
  input  logic signed [15:0]       sample,
  output logic [3:0]               code
);
  import ima_enc_pkg::*;

  logic signed [15:0] predictor, predictor_next, pred_cur;
  logic [6:0]         step_index, step_index_next, idx_cur;
  logic [14:0]        step;
  logic [16:0]        diff, mag, rem1, rem2, delta;
  logic [16:0]        st0, st1, st2;
  logic               neg, b2, b1, b0;
  logic signed [17:0] pred_wide;
  logic signed [7:0]  nidx;

  always_comb begin
    // restart clears the state before this sample is coded
    pred_cur = ctl.restart ? 16'sd0 : predictor;
    idx_cur  = ctl.restart ? 7'd0 :
               ((step_index > INDEX_MAX) ? INDEX_MAX : step_index);
    step = step_size(idx_cur);
    st0  = {2'b00, step};
    st1  = {3'b000, step[14:1]};
    st2  = {4'b0000, step[14:2]};

    diff = {sample[15], sample} - {pred_cur[15], pred_cur};
    neg  = diff[16];
    mag  = neg ? (17'd0 - diff) : diff;

    delta = {5'b00000, step[14:3]};
    b2    = (mag >= st0);
    rem1  = b2 ? (mag - st0) : mag;
    delta = b2 ? (delta + st0) : delta;
    b1    = (rem1 >= st1);
    rem2  = b1 ? (rem1 - st1) : rem1;
    delta = b1 ? (delta + st1) : delta;
    b0    = (rem2 >= st2);
    delta = b0 ? (delta + st2) : delta;

    code = {neg, b2, b1, b0};

    pred_wide = neg ? ({{2{pred_cur[15]}}, pred_cur} - $signed({1'b0, delta}))
                    : ({{2{pred_cur[15]}}, pred_cur} + $signed({1'b0, delta}));
    if (pred_wide > PRED_MAX) begin
      predictor_next = PRED_MAX[15:0];
    end else if (pred_wide < PRED_MIN) begin
      predictor_next = PRED_MIN[15:0];
    end else begin
      predictor_next = pred_wide[15:0];
    end

    nidx = $signed({1'b0, idx_cur}) + index_adjust(code[2:0]);
    if (nidx < 8'sd0) begin
      step_index_next = 7'd0;
    end else if (nidx > $signed({1'b0, INDEX_MAX})) begin
      step_index_next = INDEX_MAX;
    end else begin
      step_index_next = nidx[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor  <= '0;
      step_index <= '0;
    end else if (ctl.advance) begin
      predictor  <= predictor_next;
      step_index <= step_index_next;
    end
  end

endmodule

FILE: hdl/ima_enc_pack.sv
// Nibble packing and the output register.
`timescale 1ns / 1ps

module ima_enc_pack (
  input  logic       clk,
  input  logic       rst,
  input  logic       stage_valid,
  input  logic       restart,
  input  logic [3:0] code,
  input  logic       out_stall,
  output logic       advance,
  output logic       out_valid,
  output logic [7:0] packed_byte
);
  import ima_enc_pkg::*;

  logic       nibble_phase;
  logic [3:0] held_nibble;
  logic       emit;

  // a restart drops any held code, so this sample always goes low
  assign emit    = nibble_phase & ~restart;
  assign advance = stage_valid & (~emit | ~out_valid | ~out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_phase <= 1'b0;
      held_nibble  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // hold a stalled byte, load a new one when the pair completes
      out_valid <= (out_valid & out_stall) | (advance & emit);
      if (advance) begin
        nibble_phase <= ~emit;
        held_nibble  <= emit ? 4'd0 : code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      packed_byte <= {code, held_nibble};
    end
  end

endmodule

FILE: hdl/ima_adpcm_encoder_unit.sv
// IMA ADPCM encoder top level: input register, quantizer, packer.
//
//   channel | signals                          | transaction when
//   --------+----------------------------------+------------------------
//   input   | in_valid, in_stall, sample,      | in_valid && !in_stall
//           | restart                          |
//   output  | out_valid, out_stall,            | out_valid && !out_stall
//           | packed_byte                      |
//
// One sample per cycle unless a stalled byte holds up a pair's second sample.
// The quantizer and next-state logic are combinational off the input register.
// rst is synchronous and clears predictor, step index, phase and valids.
// A stalled output holds the byte; low-nibble samples keep flowing past it.
`timescale 1ns / 1ps

module ima_adpcm_encoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         packed_byte
);
  import ima_enc_pkg::*;

  logic               s1_valid;
  logic signed [15:0] s1_sample;
  logic               s1_restart;
  logic               advance;
  logic [3:0]         code;
  stage_ctl_t         ctl;

  assign in_stall    = s1_valid & ~advance;
  assign ctl.advance = advance;
  assign ctl.restart = s1_restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample  <= sample;
      s1_restart <= restart;
    end
  end

  ima_enc_quant u_quant (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (s1_sample),
    .code   (code)
  );

  ima_enc_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (s1_valid),
    .restart     (s1_restart),
    .code        (code),
    .out_stall   (out_stall),
    .advance     (advance),
    .out_valid   (out_valid),
    .packed_byte (packed_byte)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && in_stall) |=> (s1_valid && $stable(s1_sample) && $stable(s1_restart)))
    else $error("input register changed while stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("output byte appeared without a sample");

  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |-> s1_valid)
    else $error("state advanced without a sample");
`endif

endmodule
